FILE: rtl/etok_pkg.sv
// Shared types, codes and the character classifier for the expression tokenizer.
// Used by etok_scan and expression_tokenizer; depends on nothing else.
`default_nettype none

package etok_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ClassW = 3;

  // Scanner mode between characters.
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_LOGIC = 3'd1,
    MODE_NUM   = 3'd2,
    MODE_NAME  = 3'd3,
    MODE_ENDED = 3'd4,
    MODE_ERROR = 3'd5
  } mode_t;

  // Token class reported with each kept character.
  typedef enum logic [ClassW-1:0] {
    CLS_DELIM = 3'd0,
    CLS_LOGIC = 3'd1,
    CLS_NUM   = 3'd2,
    CLS_NAME  = 3'd3,
    CLS_END   = 3'd4,
    CLS_ERROR = 3'd5
  } cls_t;

  // Character groups seen by the scanner.
  typedef enum logic [2:0] {
    KIND_WHITE  = 3'd0,
    KIND_NUL    = 3'd1,
    KIND_DELIM  = 3'd2,
    KIND_LOGIC  = 3'd3,
    KIND_DIGIT  = 3'd4,
    KIND_LETTER = 3'd5,
    KIND_OTHER  = 3'd6
  } kind_t;

  localparam logic [CharW-1:0] CHAR_END = 8'h3B;  // ';'

  // One result of the scanner for the current character.
  typedef struct packed {
    logic             emit;
    logic [CharW-1:0] chr;
    logic             start;
    cls_t             cls;
  } scan_res_t;

  function automatic kind_t char_kind(input logic [CharW-1:0] c);
    kind_t k;
    k = KIND_OTHER;
    if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D) begin
      k = KIND_WHITE;
    end else if (c == 8'h00) begin
      k = KIND_NUL;
    end else if (c == 8'h28 || c == 8'h29 || c == 8'h2B || c == 8'h2D || c == 8'h2A ||
                 c == 8'h2F || c == 8'h2C || c == 8'h7B || c == 8'h7D || c == 8'h3B) begin
      k = KIND_DELIM;
    end else if (c == 8'h3D || c == 8'h21 || c == 8'h3C || c == 8'h3E || c == 8'h26 ||
                 c == 8'h7C) begin
      k = KIND_LOGIC;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      k = KIND_DIGIT;
    end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
      k = KIND_LETTER;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/etok_scan.sv
// Scanner state machine logic: next mode and result for one character or end of line.
// Depends on etok_pkg; purely combinational, the mode register lives in the top level.
`default_nettype none

module etok_scan (
  input  wire                       cmd_end,
  input  wire [etok_pkg::CharW-1:0] chr,
  input  wire etok_pkg::mode_t      mode,
  output etok_pkg::mode_t           mode_nxt,
  output etok_pkg::scan_res_t       res
);

  etok_pkg::kind_t  kind;
  etok_pkg::mode_t  start_mode;
  etok_pkg::cls_t   start_cls;
  logic             start_emit;

  assign kind = etok_pkg::char_kind(chr);

  // What a character does when it arrives between tokens.
  always_comb begin
    start_emit = 1'b1;
    start_mode = etok_pkg::MODE_IDLE;
    start_cls  = etok_pkg::CLS_ERROR;
    unique case (kind)
      etok_pkg::KIND_WHITE: begin
        start_emit = 1'b0;
      end
      etok_pkg::KIND_NUL: begin
        start_emit = 1'b0;
        start_mode = etok_pkg::MODE_ENDED;
      end
      etok_pkg::KIND_DELIM: begin
        start_cls = etok_pkg::CLS_DELIM;
      end
      etok_pkg::KIND_LOGIC: begin
        start_mode = etok_pkg::MODE_LOGIC;
        start_cls  = etok_pkg::CLS_LOGIC;
      end
      etok_pkg::KIND_DIGIT: begin
        start_mode = etok_pkg::MODE_NUM;
        start_cls  = etok_pkg::CLS_NUM;
      end
      etok_pkg::KIND_LETTER: begin
        start_mode = etok_pkg::MODE_NAME;
        start_cls  = etok_pkg::CLS_NAME;
      end
      default: begin
        start_mode = etok_pkg::MODE_ERROR;
      end
    endcase
  end

  // Next mode.
  always_comb begin
    mode_nxt = mode;
    if (cmd_end) begin
      mode_nxt = etok_pkg::MODE_IDLE;
    end else begin
      unique case (mode)
        etok_pkg::MODE_IDLE: begin
          mode_nxt = start_mode;
        end
        etok_pkg::MODE_LOGIC: begin
          mode_nxt = (kind == etok_pkg::KIND_LOGIC) ? etok_pkg::MODE_IDLE : start_mode;
        end
        etok_pkg::MODE_NUM, etok_pkg::MODE_NAME: begin
          if (kind == etok_pkg::KIND_WHITE || kind == etok_pkg::KIND_DELIM) begin
            mode_nxt = etok_pkg::MODE_IDLE;
          end
        end
        default: begin
          mode_nxt = mode;
        end
      endcase
    end
  end

  // Result for this character.
  always_comb begin
    res.emit  = 1'b0;
    res.chr   = chr;
    res.start = 1'b1;
    res.cls   = start_cls;
    if (cmd_end) begin
      res.emit = 1'b1;
      res.chr  = etok_pkg::CHAR_END;
      res.cls  = etok_pkg::CLS_END;
    end else begin
      unique case (mode)
        etok_pkg::MODE_IDLE: begin
          res.emit = start_emit;
        end
        etok_pkg::MODE_LOGIC: begin
          if (kind == etok_pkg::KIND_LOGIC) begin
            res.emit  = 1'b1;
            res.start = 1'b0;
            res.cls   = etok_pkg::CLS_LOGIC;
          end else begin
            res.emit = start_emit;
          end
        end
        etok_pkg::MODE_NUM, etok_pkg::MODE_NAME: begin
          if (kind == etok_pkg::KIND_DELIM) begin
            res.emit = 1'b1;
          end else if (kind != etok_pkg::KIND_WHITE) begin
            // Anything else, NUL and logical characters too, extends the token.
            res.emit  = 1'b1;
            res.start = 1'b0;
            res.cls   = (mode == etok_pkg::MODE_NUM) ? etok_pkg::CLS_NUM
                                                     : etok_pkg::CLS_NAME;
          end
        end
        default: begin
          res.emit = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/expression_tokenizer.sv
// An accepted character is held in the input register; its result is then written to the
// output register. Throughput: one character or end-of-line item per cycle while no result
// waits in the output register on out_tready low; the mode register is updated once per item
// by the scanner logic between the input and the result register.
// Items that make no result (white space, ignored characters) leave the output untouched.
// Reset (synchronous, rst_n low) empties both registers and puts the scanner between tokens.
// Top level of the expression tokenizer; depends on etok_pkg and etok_scan.
`default_nettype none

module expression_tokenizer (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] character
  input  wire  [0:0] in_tuser,   // [0] command (1 = end of line)
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [3:0] out_tuser   // [0] token_start, [3:1] token_class
);

  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_cmd_r;
  logic [etok_pkg::CharW-1:0] s1_char_r;
  etok_pkg::mode_t           mode_r, mode_nxt;
  etok_pkg::scan_res_t       res;
  logic                      out_valid_r, out_valid_nxt;
  logic [etok_pkg::CharW-1:0] out_char_r;
  logic                      out_start_r;
  etok_pkg::cls_t            out_cls_r;
  logic                      adv;
  logic                      in_xfer;

  etok_scan u_scan (
    .cmd_end  (s1_cmd_r),
    .chr      (s1_char_r),
    .mode     (mode_r),
    .mode_nxt (mode_nxt),
    .res      (res)
  );

  // The held item moves on when it makes no result or the result register is free.
  assign adv       = s1_valid_r && (!res.emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    if (adv && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= etok_pkg::MODE_IDLE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r  <= in_tuser[0];
      s1_char_r <= in_tdata;
    end
    if (adv && res.emit) begin
      out_char_r  <= res.chr;
      out_start_r <= res.start;
      out_cls_r   <= res.cls;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = {out_cls_r, out_start_r};

`ifndef ASSERT_OFF
  // An end-of-line transfer always leaves the scanner between tokens.
  a_eol_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_cmd_r |=> mode_r == etok_pkg::MODE_IDLE)
    else $error("scanner not idle after end of line");

  // An error result halts the line.
  a_err_halt: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.emit && res.cls == etok_pkg::CLS_ERROR |=> mode_r == etok_pkg::MODE_ERROR)
    else $error("error result did not halt the line");

  // A halted or ended line drops characters.
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_cmd_r &&
    (mode_r == etok_pkg::MODE_ENDED || mode_r == etok_pkg::MODE_ERROR) |-> !res.emit)
    else $error("result produced on an ended line");

  // Only logical, number and name tokens continue past their first character.
  a_cont_cls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_start_r |->
    (out_cls_r == etok_pkg::CLS_LOGIC || out_cls_r == etok_pkg::CLS_NUM ||
     out_cls_r == etok_pkg::CLS_NAME))
    else $error("continuation character with a single-character class");
`endif

endmodule

`default_nettype wire
